@@ hdl/gpioe_pkg.sv @@
// ----------------------------------------------------------------------------
// gpioe_pkg
// Shared types and constants for the GPIO controller with edge events.
// ----------------------------------------------------------------------------
package gpioe_pkg;

  // Data path and pin counts
  localparam int DATA_W       = 32;
  localparam int MAX_PINS     = 32;
  localparam int NUM_PINS_DEF = 32;
  localparam int PINS_PER_SEL = 10;
  localparam int FSEL_BITS    = 3;
  localparam int SEL_WORDS    = 4;
  localparam int IDX_W        = 4;

  // Function select code for a driven output
  localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

  // Register word indices
  localparam logic [IDX_W-1:0] REG_SET    = 4'd4;
  localparam logic [IDX_W-1:0] REG_CLR    = 4'd5;
  localparam logic [IDX_W-1:0] REG_LEVELS = 4'd6;
  localparam logic [IDX_W-1:0] REG_EVENT  = 4'd7;
  localparam logic [IDX_W-1:0] REG_RISE   = 4'd8;
  localparam logic [IDX_W-1:0] REG_FALL   = 4'd9;

  // Operation codes
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  // One bus access or sample tick
  typedef struct packed {
    op_e               operation;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] pin_levels;
  } item_t;

  // One result
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pin_drive;
    logic [DATA_W-1:0] pin_output_enable;
    logic              interrupt;
  } result_t;

endpackage

@@ hdl/gpioe_in_reg.sv @@
// ----------------------------------------------------------------------------
// gpioe_in_reg
// Input register: holds one item until the core takes it.
// ----------------------------------------------------------------------------
module gpioe_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  gpioe_pkg::item_t in_item,
  input  logic            advance,
  output logic            full,
  output gpioe_pkg::item_t item
);
  import gpioe_pkg::*;

  logic accept;

  // Stall only while holding an item that cannot move on
  assign in_stall = full && !advance;
  assign accept   = in_valid && !in_stall;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

@@ hdl/gpioe_core.sv @@
// ----------------------------------------------------------------------------
// gpioe_core
// Register file, edge detect and result formation for one item per cycle while fire is asserted.
// ----------------------------------------------------------------------------
module gpioe_core #(
  parameter int NUM_PINS = gpioe_pkg::NUM_PINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  gpioe_pkg::item_t   item,
  output gpioe_pkg::result_t result
);
  import gpioe_pkg::*;

  localparam logic [DATA_W-1:0] PIN_MASK = DATA_W'((64'd1 << NUM_PINS) - 64'd1);

  logic [FSEL_BITS-1:0] fsel      [NUM_PINS];
  logic [FSEL_BITS-1:0] fsel_next [NUM_PINS];
  logic [DATA_W-1:0]    sel_word  [SEL_WORDS];

  logic [DATA_W-1:0] out_latch, out_latch_next;
  logic [DATA_W-1:0] rise_en, rise_en_next;
  logic [DATA_W-1:0] fall_en, fall_en_next;
  logic [DATA_W-1:0] evt_status, evt_status_next;
  logic [DATA_W-1:0] levels, levels_next;
  logic [DATA_W-1:0] now_levels, rose, fell;
  logic [DATA_W-1:0] rd, oe_next;
  logic              sel_write;

  assign sel_write = (item.operation == OP_WRITE) && (item.reg_index < IDX_W'(SEL_WORDS));

  // Select word read-back, unused pins and top two bits read as zero
  for (genvar w = 0; w < SEL_WORDS; w++) begin : g_word
    for (genvar i = 0; i < PINS_PER_SEL; i++) begin : g_slot
      localparam int P = w * PINS_PER_SEL + i;
      if (P < NUM_PINS) begin : g_used
        assign sel_word[w][FSEL_BITS*i +: FSEL_BITS] = fsel[P];
      end else begin : g_unused
        assign sel_word[w][FSEL_BITS*i +: FSEL_BITS] = '0;
      end
    end
    assign sel_word[w][DATA_W-1 : FSEL_BITS*PINS_PER_SEL] = '0;
  end

  // Per-pin function select and output enable
  for (genvar p = 0; p < MAX_PINS; p++) begin : g_pin
    if (p < NUM_PINS) begin : g_used
      localparam int W = p / PINS_PER_SEL;
      localparam int S = p % PINS_PER_SEL;

      always_comb begin
        fsel_next[p] = fsel[p];
        if (sel_write && (item.reg_index == IDX_W'(W))) begin
          fsel_next[p] = item.write_data[FSEL_BITS*S +: FSEL_BITS];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          fsel[p] <= '0;
        end else if (fire) begin
          fsel[p] <= fsel_next[p];
        end
      end

      assign oe_next[p] = (fsel_next[p] == FSEL_OUTPUT);
    end else begin : g_unused
      assign oe_next[p] = 1'b0;
    end
  end

  // Register read mux
  always_comb begin
    rd = '0;
    if (item.reg_index < IDX_W'(SEL_WORDS)) begin
      rd = sel_word[item.reg_index[1:0]];
    end else begin
      unique case (item.reg_index)
        REG_LEVELS: rd = levels;
        REG_EVENT:  rd = evt_status;
        REG_RISE:   rd = rise_en;
        REG_FALL:   rd = fall_en;
        default:    rd = '0;
      endcase
    end
  end

  // Edge detect against the previous sample
  assign now_levels = item.pin_levels & PIN_MASK;
  assign rose       = now_levels & ~levels & rise_en;
  assign fell       = ~now_levels & levels & fall_en;

  // Next state for the word registers
  always_comb begin
    out_latch_next  = out_latch;
    rise_en_next    = rise_en;
    fall_en_next    = fall_en;
    evt_status_next = evt_status;
    levels_next     = levels;
    case (item.operation)
      OP_WRITE: begin
        unique case (item.reg_index)
          REG_SET:   out_latch_next  = (out_latch | item.write_data) & PIN_MASK;
          REG_CLR:   out_latch_next  = out_latch & ~item.write_data & PIN_MASK;
          REG_EVENT: evt_status_next = evt_status & ~item.write_data & PIN_MASK;
          REG_RISE:  rise_en_next    = item.write_data & PIN_MASK;
          REG_FALL:  fall_en_next    = item.write_data & PIN_MASK;
          default: ;
        endcase
      end
      OP_SAMPLE: begin
        evt_status_next = (evt_status | rose | fell) & PIN_MASK;
        levels_next     = now_levels;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_latch  <= '0;
      rise_en    <= '0;
      fall_en    <= '0;
      evt_status <= '0;
      levels     <= '0;
    end else if (fire) begin
      out_latch  <= out_latch_next;
      rise_en    <= rise_en_next;
      fall_en    <= fall_en_next;
      evt_status <= evt_status_next;
      levels     <= levels_next;
    end
  end

  // Result reflects state after the item
  assign result.read_data         = (item.operation == OP_READ) ? rd : '0;
  assign result.pin_drive         = out_latch_next;
  assign result.pin_output_enable = oe_next;
  assign result.interrupt         = |evt_status_next;

endmodule

@@ hdl/gpioe_out_reg.sv @@
// ----------------------------------------------------------------------------
// gpioe_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module gpioe_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  gpioe_pkg::result_t res_in,
  input  logic               out_stall,
  output logic               out_valid,
  output gpioe_pkg::result_t res
);
  import gpioe_pkg::*;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

@@ hdl/gpio_controller_edge_events_top.sv @@
// ----------------------------------------------------------------------------
// gpio_controller_edge_events_top
// GPIO controller with register access, output latch and edge event status.
// ----------------------------------------------------------------------------
// Each item (bus read, bus write or sample tick) yields one result. Items pass
// an input register, then the register-file logic that loads the result
// register, so one item is taken every clock while results are drained. A
// stalled result still lets one further item wait in the input register.
module gpio_controller_edge_events_top #(
  parameter int NUM_PINS = gpioe_pkg::NUM_PINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [31:0] pin_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [31:0] pin_drive,
  output logic [31:0] pin_output_enable,
  output logic        interrupt
);
  import gpioe_pkg::*;

  localparam logic [DATA_W-1:0] PIN_MASK = DATA_W'((64'd1 << NUM_PINS) - 64'd1);

  item_t   in_item, item;
  result_t res_next, res;
  logic    full, advance;

  assign in_item.operation  = op_e'(operation);
  assign in_item.reg_index  = reg_index;
  assign in_item.write_data = write_data;
  assign in_item.pin_levels = pin_levels;

  // Held item moves on when the result slot is free or being drained
  assign advance = full && (!out_valid || !out_stall);

  gpioe_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .full     (full),
    .item     (item)
  );

  gpioe_core #(
    .NUM_PINS (NUM_PINS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item),
    .result (res_next)
  );

  gpioe_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (res_next),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res)
  );

  assign read_data         = res.read_data;
  assign pin_drive         = res.pin_drive;
  assign pin_output_enable = res.pin_output_enable;
  assign interrupt         = res.interrupt;

`ifndef SYNTHESIS
  // An empty input register never stalls the source
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !full |-> !in_stall)
    else $error("input stalled while input register empty");

  // A transfer into the result register shows up as a valid result
  a_adv_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  // Pins beyond the configured count stay quiet
  a_unused_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pin_output_enable & ~PIN_MASK) == '0) && ((pin_drive & ~PIN_MASK) == '0))
    else $error("unused pin bits set");
`endif

endmodule
